### rtl/satt_pkg.sv
// ----------------------------------------------------------------------------
// satt_pkg: shared types and constants of the sleep/alarm timer table
// Table geometry, request and event codes, table entry layout, the write
// command into the table and the operation codes of the shared ALU.
// ----------------------------------------------------------------------------
package satt_pkg;

  localparam int MAX_TIMERS   = 16;
  localparam int IDX_W        = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int RESULT_LIMIT = 16;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  localparam int PADDR_W = 3;
  localparam logic [0:0]  REG_SCAN_INTERVAL = 1'b0;
  localparam logic [15:0] SCAN_INTERVAL_RST = 16'd50;

  localparam logic [30:0] SEC_MAX  = 31'h7FFF_FFFF;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_TICK         = 2'd0,
    FUNC_ADD_SLEEP    = 2'd1,
    FUNC_SET_ALARM    = 2'd2,
    FUNC_REMOVE_SLEEP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_WAKE   = 2'd0,
    KIND_SIGNAL = 2'd1,
    KIND_REPLY  = 2'd2
  } kind_t;

  typedef enum logic {
    TYPE_SLEEP = 1'b0,
    TYPE_ALARM = 1'b1
  } ttype_t;

  typedef struct packed {
    ttype_t      typ;
    logic [15:0] owner;
    logic [31:0] expiry;
  } entry_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  typedef enum logic [1:0] {
    ALU_LE   = 2'd0,
    ALU_LEFT = 2'd1,
    ALU_SUM  = 2'd2
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_SCAN  = 3'd1,
    S_FLUSH = 3'd2,
    S_LOOK  = 3'd3,
    S_LEFT  = 3'd4,
    S_REPLY = 3'd5
  } state_t;

endpackage

### rtl/satt_alu.sv
// ----------------------------------------------------------------------------
// satt_alu: shared 33-bit add/subtract unit
// Expiry compare, seconds left (clamped and saturated) and saturating
// expiry sum, all through one adder.
// ----------------------------------------------------------------------------
module satt_alu (
  input  satt_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       res,
  output logic              flag
);

  logic        sub;
  logic [32:0] sum;
  logic        a_le_b;

  assign sub    = (op != satt_pkg::ALU_SUM);
  assign sum    = {1'b0, a} + (sub ? ~{1'b0, b} : {1'b0, b}) + {32'd0, sub};
  // borrow out of the subtract means a < b
  assign a_le_b = sum[32] || (sum[31:0] == 32'd0);

  always_comb begin
    res  = 32'd0;
    flag = 1'b0;
    case (op)
      satt_pkg::ALU_LE: begin
        flag = a_le_b;
      end
      satt_pkg::ALU_LEFT: begin
        flag = a_le_b;
        if (a_le_b) begin
          res = 32'd0;
        end else if (sum[31]) begin
          res = {1'b0, satt_pkg::SEC_MAX};
        end else begin
          res = sum[31:0];
        end
      end
      satt_pkg::ALU_SUM: begin
        flag = sum[32];
        res  = sum[32] ? satt_pkg::TIME_MAX : sum[31:0];
      end
      default: begin
        res  = 32'd0;
        flag = 1'b0;
      end
    endcase
  end

endmodule

### rtl/satt_table.sv
// ----------------------------------------------------------------------------
// satt_table: timer entry storage
// Per-entry valid flops cleared by reset, entry payload without reset,
// one read port at the sequencer index and one write port.
// ----------------------------------------------------------------------------
module satt_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [satt_pkg::IDX_W-1:0]  rd_idx,
  output logic                        rd_vld,
  output satt_pkg::entry_t            rd_entry,
  input  satt_pkg::tbl_wr_t           wr
);

  logic [satt_pkg::MAX_TIMERS-1:0] vld_r;
  satt_pkg::entry_t                ent_r [satt_pkg::MAX_TIMERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.set) begin
      vld_r[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      vld_r[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      ent_r[wr.idx] <= wr.data;
    end
  end

  assign rd_vld   = vld_r[rd_idx];
  assign rd_entry = ent_r[rd_idx];

endmodule

### rtl/satt_ctrl.sv
// ----------------------------------------------------------------------------
// satt_ctrl: request sequencer
// Walks the table one entry per cycle (a scan waits out output stalls) for
// expiry scans and owner/free lookups; drives the shared ALU, holds the result register.
// ----------------------------------------------------------------------------
module satt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [15:0]                 scan_interval,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [31:0]                 in_current_time,
  input  logic [15:0]                 in_owner,
  input  logic [30:0]                 in_seconds,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [15:0]                 out_target,
  output logic [30:0]                 out_remaining,
  output logic                        out_full_error,
  output logic                        out_last,
  output logic [satt_pkg::IDX_W-1:0]  rd_idx,
  input  logic                        rd_vld,
  input  satt_pkg::entry_t            rd_entry,
  output satt_pkg::tbl_wr_t           tbl_wr,
  output satt_pkg::alu_op_t           alu_op,
  output logic [31:0]                 alu_a,
  output logic [31:0]                 alu_b,
  input  logic [31:0]                 alu_res,
  input  logic                        alu_flag
);

  satt_pkg::state_t state_r, state_nxt;

  satt_pkg::func_t              func_r, func_nxt;
  logic [31:0]                  now_r, now_nxt;
  logic [15:0]                  who_r, who_nxt;
  logic [30:0]                  secs_r, secs_nxt;
  logic [satt_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [satt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [15:0]                  phase_r, phase_nxt;

  logic                         pend_vld_r, pend_vld_nxt;
  satt_pkg::kind_t              pend_kind_r, pend_kind_nxt;
  logic [15:0]                  pend_tgt_r, pend_tgt_nxt;

  logic                         free_fnd_r, free_fnd_nxt;
  logic [satt_pkg::IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic                         own_fnd_r, own_fnd_nxt;
  logic [satt_pkg::IDX_W-1:0]   own_idx_r, own_idx_nxt;
  logic [31:0]                  own_time_r, own_time_nxt;

  logic                         out_valid_r, out_valid_nxt;
  satt_pkg::kind_t              out_kind_r, out_kind_nxt;
  logic [15:0]                  out_tgt_r, out_tgt_nxt;
  logic [30:0]                  out_rem_r, out_rem_nxt;
  logic                         out_full_r, out_full_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         accept;
  satt_pkg::func_t              in_fn;
  logic [16:0]                  phase_inc;
  logic                         scan_due;
  logic                         out_free;
  logic                         last_idx;
  logic                         scan_hit;
  logic                         scan_stall;
  satt_pkg::ttype_t             want_type;
  logic                         own_hit;

  assign in_ready  = (state_r == satt_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_fn     = satt_pkg::func_t'(in_func);
  assign phase_inc = {1'b0, phase_r} + 17'd1;
  assign scan_due  = !(phase_inc < {1'b0, scan_interval});
  assign out_free  = !out_valid_r || out_ready;
  assign last_idx  = (idx_r == satt_pkg::IDX_W'(satt_pkg::MAX_TIMERS - 1));
  assign rd_idx    = idx_r;

  assign scan_hit   = rd_vld && alu_flag &&
                      (cnt_r < satt_pkg::CNT_W'(satt_pkg::RESULT_LIMIT));
  assign scan_stall = scan_hit && pend_vld_r && !out_free;
  assign want_type  = (func_r == satt_pkg::FUNC_SET_ALARM) ? satt_pkg::TYPE_ALARM
                                                           : satt_pkg::TYPE_SLEEP;
  assign own_hit    = rd_vld && (rd_entry.owner == who_r) && (rd_entry.typ == want_type);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      satt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_fn != satt_pkg::FUNC_TICK) begin
            state_nxt = satt_pkg::S_LOOK;
          end else if (scan_due) begin
            state_nxt = satt_pkg::S_SCAN;
          end
        end
      end
      satt_pkg::S_SCAN: begin
        if (!scan_stall && last_idx) state_nxt = satt_pkg::S_FLUSH;
      end
      satt_pkg::S_FLUSH: begin
        if (!pend_vld_r || out_free) state_nxt = satt_pkg::S_IDLE;
      end
      satt_pkg::S_LOOK: begin
        if (last_idx) state_nxt = satt_pkg::S_LEFT;
      end
      satt_pkg::S_LEFT: begin
        state_nxt = satt_pkg::S_REPLY;
      end
      satt_pkg::S_REPLY: begin
        if (out_free) state_nxt = satt_pkg::S_IDLE;
      end
      default: state_nxt = satt_pkg::S_IDLE;
    endcase
  end

  // datapath, table writes, ALU control and result register
  always_comb begin
    func_nxt      = func_r;
    now_nxt       = now_r;
    who_nxt       = who_r;
    secs_nxt      = secs_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    pend_vld_nxt  = pend_vld_r;
    pend_kind_nxt = pend_kind_r;
    pend_tgt_nxt  = pend_tgt_r;
    free_fnd_nxt  = free_fnd_r;
    free_idx_nxt  = free_idx_r;
    own_fnd_nxt   = own_fnd_r;
    own_idx_nxt   = own_idx_r;
    own_time_nxt  = own_time_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_tgt_nxt   = out_tgt_r;
    out_rem_nxt   = out_rem_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    tbl_wr        = '0;
    alu_op        = satt_pkg::ALU_LE;
    alu_a         = rd_entry.expiry;
    alu_b         = now_r;

    unique case (state_r)
      satt_pkg::S_IDLE: begin
        if (accept) begin
          func_nxt     = in_fn;
          now_nxt      = in_current_time;
          who_nxt      = in_owner;
          secs_nxt     = in_seconds;
          idx_nxt      = '0;
          cnt_nxt      = '0;
          free_fnd_nxt = 1'b0;
          own_fnd_nxt  = 1'b0;
          pend_vld_nxt = 1'b0;
          if (in_fn == satt_pkg::FUNC_TICK) begin
            phase_nxt = scan_due ? 16'd0 : phase_inc[15:0];
          end
        end
      end
      satt_pkg::S_SCAN: begin
        if (!scan_stall) begin
          if (scan_hit) begin
            // push the held event out, hold the new one until its successor or the flush
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_tgt_nxt   = pend_tgt_r;
              out_rem_nxt   = '0;
              out_full_nxt  = 1'b0;
              out_last_nxt  = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_kind_nxt = (rd_entry.typ == satt_pkg::TYPE_ALARM) ? satt_pkg::KIND_SIGNAL
                                                                   : satt_pkg::KIND_WAKE;
            pend_tgt_nxt  = rd_entry.owner;
            cnt_nxt       = cnt_r + satt_pkg::CNT_W'(1);
            if (rd_entry.typ == satt_pkg::TYPE_ALARM) begin
              tbl_wr.clr = 1'b1;
              tbl_wr.idx = idx_r;
            end
          end
          idx_nxt = idx_r + satt_pkg::IDX_W'(1);
        end
      end
      satt_pkg::S_FLUSH: begin
        if (pend_vld_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_tgt_nxt   = pend_tgt_r;
          out_rem_nxt   = '0;
          out_full_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          pend_vld_nxt  = 1'b0;
        end
      end
      satt_pkg::S_LOOK: begin
        if (!rd_vld && !free_fnd_r) begin
          free_fnd_nxt = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (own_hit && !own_fnd_r) begin
          own_fnd_nxt  = 1'b1;
          own_idx_nxt  = idx_r;
          own_time_nxt = rd_entry.expiry;
        end
        idx_nxt = idx_r + satt_pkg::IDX_W'(1);
      end
      satt_pkg::S_LEFT: begin
        alu_op       = satt_pkg::ALU_LEFT;
        alu_a        = own_time_r;
        alu_b        = now_r;
        own_time_nxt = alu_res;
      end
      satt_pkg::S_REPLY: begin
        alu_op = satt_pkg::ALU_SUM;
        alu_a  = now_r;
        alu_b  = {1'b0, secs_r};
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = satt_pkg::KIND_REPLY;
          out_tgt_nxt   = who_r;
          out_rem_nxt   = '0;
          out_full_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          tbl_wr.data.owner  = who_r;
          tbl_wr.data.expiry = alu_res;
          tbl_wr.data.typ    = want_type;
          case (func_r)
            satt_pkg::FUNC_ADD_SLEEP: begin
              if (free_fnd_r) begin
                tbl_wr.set = 1'b1;
                tbl_wr.idx = free_idx_r;
              end else begin
                out_rem_nxt  = secs_r;
                out_full_nxt = 1'b1;
              end
            end
            satt_pkg::FUNC_SET_ALARM: begin
              if (own_fnd_r) begin
                out_rem_nxt = own_time_r[30:0];
                tbl_wr.idx  = own_idx_r;
                if (secs_r != '0) begin
                  tbl_wr.set = 1'b1;
                end else begin
                  tbl_wr.clr = 1'b1;
                end
              end else if (secs_r == '0) begin
                out_rem_nxt = '0;
              end else if (free_fnd_r) begin
                tbl_wr.set = 1'b1;
                tbl_wr.idx = free_idx_r;
              end else begin
                out_rem_nxt  = secs_r;
                out_full_nxt = 1'b1;
              end
            end
            satt_pkg::FUNC_REMOVE_SLEEP: begin
              if (own_fnd_r) begin
                out_rem_nxt = own_time_r[30:0];
                tbl_wr.clr  = 1'b1;
                tbl_wr.idx  = own_idx_r;
              end
            end
            default: begin
              out_rem_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= satt_pkg::S_IDLE;
      phase_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    now_r       <= now_nxt;
    who_r       <= who_nxt;
    secs_r      <= secs_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_tgt_r  <= pend_tgt_nxt;
    free_fnd_r  <= free_fnd_nxt;
    free_idx_r  <= free_idx_nxt;
    own_fnd_r   <= own_fnd_nxt;
    own_idx_r   <= own_idx_nxt;
    own_time_r  <= own_time_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tgt_r   <= out_tgt_nxt;
    out_rem_r   <= out_rem_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_target     = out_tgt_r;
  assign out_remaining  = out_rem_r;
  assign out_full_error = out_full_r;
  assign out_last       = out_last_r;

  a_req_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_fn != satt_pkg::FUNC_TICK) |=> state_r == satt_pkg::S_LOOK)
    else $error("request did not start a table lookup");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == satt_pkg::S_IDLE |-> !pend_vld_r)
    else $error("event left behind after scan");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == satt_pkg::KIND_REPLY) |-> out_last_r)
    else $error("reply beat without last");

  a_full_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> out_kind_r == satt_pkg::KIND_REPLY)
    else $error("full error on an event beat");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == satt_pkg::S_SCAN |-> cnt_r <= satt_pkg::CNT_W'(satt_pkg::RESULT_LIMIT))
    else $error("scan event count past limit");

endmodule

### rtl/sleep_alarm_timer_table.sv
// ----------------------------------------------------------------------------
// sleep_alarm_timer_table: table of sleep and alarm wakeup timers
// Operation: a tick that does not fall on a scan gives no beat; a scanning
//   tick walks all MAX_TIMERS entries and flushes the held event, waiting on
//   output stalls; a request walks all entries, takes the seconds left, then gives its reply beat.
// Throughput: one item at a time; the one-entry-per-cycle walk, bar output stalls, sets the rate.
// Reset: rst_n (synchronous) clears all valid bits, the tick phase and the
//   output beat; scan_interval returns to 50.
// ----------------------------------------------------------------------------
module sleep_alarm_timer_table (
  input  logic                          clk,
  input  logic                          rst_n,
  // request and tick channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [31:0]                   in_current_time,
  input  logic [15:0]                   in_owner,
  input  logic [30:0]                   in_seconds,
  // event and reply channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [15:0]                   out_target,
  output logic [30:0]                   out_remaining,
  output logic                          out_full_error,
  output logic                          out_last,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [satt_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [15:0]                 scan_interval_r, scan_interval_nxt;
  logic                        cfg_wr;
  logic [0:0]                  cfg_reg_idx;

  logic [satt_pkg::IDX_W-1:0]  rd_idx;
  logic                        rd_vld;
  satt_pkg::entry_t            rd_entry;
  satt_pkg::tbl_wr_t           tbl_wr;
  satt_pkg::alu_op_t           alu_op;
  logic [31:0]                 alu_a;
  logic [31:0]                 alu_b;
  logic [31:0]                 alu_res;
  logic                        alu_flag;

  // Configuration: one register per 32-bit word, index from the word address.
  // The access needs no wait state, so pready stays high.
  assign pready      = 1'b1;
  assign cfg_reg_idx = paddr[satt_pkg::PADDR_W-1:2];
  assign cfg_wr      = psel && penable && pwrite && pready;

  always_comb begin
    scan_interval_nxt = scan_interval_r;
    if (cfg_wr && (cfg_reg_idx == satt_pkg::REG_SCAN_INTERVAL)) begin
      scan_interval_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_interval_r <= satt_pkg::SCAN_INTERVAL_RST;
    end else begin
      scan_interval_r <= scan_interval_nxt;
    end
  end

  // Read back: anything past the register list reads as zero.
  always_comb begin
    prdata = 32'd0;
    unique case (cfg_reg_idx)
      satt_pkg::REG_SCAN_INTERVAL: prdata = {16'd0, scan_interval_r};
      default:                     prdata = 32'd0;
    endcase
  end

  // Sequencer: tick phase, table walks, reply building and the output beat.
  satt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .scan_interval   (scan_interval_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_current_time (in_current_time),
    .in_owner        (in_owner),
    .in_seconds      (in_seconds),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_target      (out_target),
    .out_remaining   (out_remaining),
    .out_full_error  (out_full_error),
    .out_last        (out_last),
    .rd_idx          (rd_idx),
    .rd_vld          (rd_vld),
    .rd_entry        (rd_entry),
    .tbl_wr          (tbl_wr),
    .alu_op          (alu_op),
    .alu_a           (alu_a),
    .alu_b           (alu_b),
    .alu_res         (alu_res),
    .alu_flag        (alu_flag)
  );

  // Timer storage: valid bits under reset, payload written on insert/update.
  satt_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .rd_vld   (rd_vld),
    .rd_entry (rd_entry),
    .wr       (tbl_wr)
  );

  // Shared adder: expiry compare during scans, seconds left and the
  // saturating expiry sum while building a reply.
  satt_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flag (alu_flag)
  );

endmodule
